// File: hw/rtl/quaternion_to_euler_angles_macros.svh
// assertion helpers for the quaternion to euler angle converter
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// property that must hold at every clock edge outside reset
`define QTE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("quaternion_to_euler_angles: invariant check failed");

// property that must hold whenever its condition is true
`define QTE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion_to_euler_angles: implication check failed");

`endif

// File: hw/rtl/qte_pkg.sv
package qte_pkg;

  // angle accumulator precision, 2^(ANGLE_BITS-1) is pi
  localparam int ANGLE_BITS   = 16;
  // vectoring iterations per arctangent
  localparam int CORDIC_STEPS = 16;

  // datapath width of the cordic x and y lanes
  localparam int CW = 36;
  // angle accumulator width
  localparam int ZW = ANGLE_BITS + 2;
  // square root radicand and root width
  localparam int SQ_W = 57;
  // one root bit per cell
  localparam int SQ_STEPS = 29;
  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  // pipeline depth of one arctangent unit
  localparam int CORD_LAT = CORDIC_STEPS + 2;
  // extra depth of the pitch path ahead of its arctangent unit
  localparam int SQ_LAT = SQ_STEPS + 2;

  localparam int TAB_SHIFT = 32 - ANGLE_BITS;
  localparam int TAB_RND   = (TAB_SHIFT > 0) ? TAB_SHIFT - 1 : 0;

  localparam logic signed [CW-1:0] Q28_ONE = 36'sd268435456;
  localparam logic signed [ZW-1:0] HALF_TURN = {2'b00, 1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [SQ_W-1:0] SQ_ONE = {1'b1, {(SQ_W-1){1'b0}}};
  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

  // sideband tag bits carried along the pitch path
  localparam int TAG_POS = 0;
  localparam int TAG_NEG = 1;

  // arctangent of 2^-i, 2^31 is pi
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [1:0]           tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           tag;
    logic signed [CW-1:0] s;
    logic [SQ_W-1:0]      v;
    logic [SQ_W-1:0]      r;
    logic [SQ_W-1:0]      b;
  } sqrt_t;

  // table entry rounded half up to the accumulator precision
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [32:0] t;
    t = {1'b0, ATAN_TAB[idx]};
    if (TAB_SHIFT != 0) begin
      t = (t + (33'd1 << TAB_RND)) >> TAB_SHIFT;
    end
    return ZW'(t);
  endfunction

endpackage

// File: hw/rtl/qte_isqrt_cell.sv
module qte_isqrt_cell (
  input  logic              clk,
  input  logic              rst,
  input  qte_pkg::sqrt_t    din,
  output qte_pkg::sqrt_t    dout
);

  logic [qte_pkg::SQ_W:0] trial;
  logic                   ge;
  qte_pkg::sqrt_t         nxt;

  // one root bit: subtract the trial value when it fits
  always_comb begin
    trial = {1'b0, din.r} + {1'b0, din.b};
    ge    = {1'b0, din.v} >= trial;
    nxt   = din;
    if (ge) begin
      nxt.v = din.v - trial[qte_pkg::SQ_W-1:0];
      nxt.r = (din.r >> 1) + din.b;
    end else begin
      nxt.r = din.r >> 1;
    end
    nxt.b = din.b >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) dout <= '0;
    else     dout <= nxt;
  end

endmodule

// File: hw/rtl/qte_cordic_cell.sv
module qte_cordic_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [qte_pkg::STEP_W-1:0]  step,
  input  qte_pkg::cordic_t            din,
  output qte_pkg::cordic_t            dout
);

  logic signed [qte_pkg::CW-1:0] xs;
  logic signed [qte_pkg::CW-1:0] ys;
  logic signed [qte_pkg::ZW-1:0] at;
  qte_pkg::cordic_t              nxt;

  // one vectoring micro-rotation toward the x axis
  always_comb begin
    xs  = din.x >>> step;
    ys  = din.y >>> step;
    at  = qte_pkg::atan_entry(5'(step));
    nxt = din;
    if (din.y < 0) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout <= '0;
    else     dout <= nxt;
  end

endmodule

// File: hw/rtl/qte_cordic.sv
module qte_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  logic [1:0]                    tag_in,
  input  logic signed [qte_pkg::CW-1:0] y_in,
  input  logic signed [qte_pkg::CW-1:0] x_in,
  output logic                          valid_out,
  output logic [1:0]                    tag_out,
  output logic signed [15:0]            angle
);

  qte_pkg::cordic_t link [qte_pkg::CORDIC_STEPS+1];
  qte_pkg::cordic_t last;
  logic signed [15:0] ang;

  // fold the left half plane over by a half turn
  always_ff @(posedge clk) begin
    link[0].zero <= (x_in == 0) && (y_in == 0);
    link[0].tag  <= tag_in;
    if (x_in < 0) begin
      link[0].x <= -x_in;
      link[0].y <= -y_in;
      link[0].z <= (y_in < 0) ? -qte_pkg::HALF_TURN : qte_pkg::HALF_TURN;
    end else begin
      link[0].x <= x_in;
      link[0].y <= y_in;
      link[0].z <= '0;
    end
    if (rst) link[0].valid <= 1'b0;
    else     link[0].valid <= valid_in;
  end

  // row of micro-rotation cells
  for (genvar i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin : g_cell
    qte_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (qte_pkg::STEP_W'(i)),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign last = link[qte_pkg::CORDIC_STEPS];

  // scale the accumulator to the 16 bit output angle
  if (qte_pkg::ANGLE_BITS > 16) begin : g_round
    localparam int D = qte_pkg::ANGLE_BITS - 16;
    localparam logic signed [qte_pkg::ZW:0] RND = (qte_pkg::ZW+1)'(1) << (D - 1);
    logic signed [qte_pkg::ZW:0] zr;
    assign zr  = $signed({last.z[qte_pkg::ZW-1], last.z}) + RND;
    assign ang = 16'(zr >>> D);
  end else if (qte_pkg::ANGLE_BITS == 16) begin : g_same
    assign ang = last.z[15:0];
  end else begin : g_widen
    logic signed [15:0] zx;
    assign zx  = 16'(last.z);
    assign ang = zx <<< (16 - qte_pkg::ANGLE_BITS);
  end

  always_ff @(posedge clk) begin
    angle   <= last.zero ? 16'sd0 : ang;
    tag_out <= last.tag;
    if (rst) valid_out <= 1'b0;
    else     valid_out <= last.valid;
  end

endmodule

// File: hw/rtl/quaternion_to_euler_angles.sv
// Converts a unit quaternion (Q2.14) to roll, pitch and yaw binary angles
// (32768 = pi). A quaternion is taken on every cycle that start is high; busy
// stays low. Each result appears on done for one cycle, after passing the
// 29-cell square root row and the CORDIC_STEPS-cell arctangent row of the
// pitch path. The receiver cannot stall the block, so results must be taken
// on the cycle they appear.
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);

  localparam int CW = qte_pkg::CW;

  logic v1, v2, v3;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic signed [CW-1:0] sr, cr, sp, sy, cy;
  logic signed [CW-1:0] sp3;
  logic [1:0] tag2, tag3;
  logic signed [28:0] sp_low;
  logic signed [57:0] sp_sq;
  logic [qte_pkg::SQ_W-1:0] s2;
  qte_pkg::sqrt_t sq [qte_pkg::SQ_STEPS+1];
  qte_pkg::sqrt_t sq_out;

  logic roll_valid, yaw_valid, pitch_valid;
  logic [1:0] roll_tag, yaw_tag, pitch_tag;
  logic signed [15:0] roll_ang, yaw_ang, pitch_ang;
  logic signed [15:0] roll_d [qte_pkg::SQ_LAT];
  logic signed [15:0] yaw_d  [qte_pkg::SQ_LAT];

  assign busy = 1'b0;

  // pairwise products of the components
  always_ff @(posedge clk) begin
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wy <= quat_w * quat_y;
    p_zx <= quat_z * quat_x;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_zz <= quat_z * quat_z;
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  // sine and cosine operands in Q28
  always_ff @(posedge clk) begin
    sr <= (CW'(p_wx) + CW'(p_yz)) <<< 1;
    cr <= qte_pkg::Q28_ONE - ((CW'(p_xx) + CW'(p_yy)) <<< 1);
    sp <= (CW'(p_wy) - CW'(p_zx)) <<< 1;
    sy <= (CW'(p_wz) + CW'(p_xy)) <<< 1;
    cy <= qte_pkg::Q28_ONE - ((CW'(p_yy) + CW'(p_zz)) <<< 1);
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  // pitch saturation flags
  always_comb begin
    tag2 = '0;
    tag2[qte_pkg::TAG_POS] = sp >= qte_pkg::Q28_ONE;
    tag2[qte_pkg::TAG_NEG] = sp <= -qte_pkg::Q28_ONE;
  end

  // square of the pitch sine, exact while it stays below one
  assign sp_low = sp[28:0];
  assign sp_sq  = sp_low * sp_low;

  always_ff @(posedge clk) begin
    s2   <= sp_sq[qte_pkg::SQ_W-1:0];
    sp3  <= sp;
    tag3 <= tag2;
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  // radicand one minus sine squared
  always_ff @(posedge clk) begin
    sq[0].tag <= tag3;
    sq[0].s   <= sp3;
    sq[0].v   <= qte_pkg::SQ_ONE - s2;
    sq[0].r   <= '0;
    sq[0].b   <= qte_pkg::SQ_ONE;
    if (rst) sq[0].valid <= 1'b0;
    else     sq[0].valid <= v3;
  end

  // square root row, one root bit per cell
  for (genvar i = 0; i < qte_pkg::SQ_STEPS; i++) begin : g_sq
    qte_isqrt_cell u_sq (
      .clk  (clk),
      .rst  (rst),
      .din  (sq[i]),
      .dout (sq[i+1])
    );
  end

  assign sq_out = sq[qte_pkg::SQ_STEPS];

  qte_cordic u_roll (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v2),
    .tag_in    (2'b00),
    .y_in      (sr),
    .x_in      (cr),
    .valid_out (roll_valid),
    .tag_out   (roll_tag),
    .angle     (roll_ang)
  );

  qte_cordic u_yaw (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v2),
    .tag_in    (2'b00),
    .y_in      (sy),
    .x_in      (cy),
    .valid_out (yaw_valid),
    .tag_out   (yaw_tag),
    .angle     (yaw_ang)
  );

  qte_cordic u_pitch (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sq_out.valid),
    .tag_in    (sq_out.tag),
    .y_in      (sq_out.s),
    .x_in      (CW'(sq_out.r)),
    .valid_out (pitch_valid),
    .tag_out   (pitch_tag),
    .angle     (pitch_ang)
  );

  // hold roll and yaw until the pitch path catches up
  always_ff @(posedge clk) begin
    roll_d[0] <= roll_ang;
    yaw_d[0]  <= yaw_ang;
    for (int i = 1; i < qte_pkg::SQ_LAT; i++) begin
      roll_d[i] <= roll_d[i-1];
      yaw_d[i]  <= yaw_d[i-1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    roll_angle    <= roll_d[qte_pkg::SQ_LAT-1];
    yaw_angle     <= yaw_d[qte_pkg::SQ_LAT-1];
    pitch_clamped <= |pitch_tag;
    if (pitch_tag[qte_pkg::TAG_POS]) begin
      pitch_angle <= qte_pkg::PITCH_MAX;
    end else if (pitch_tag[qte_pkg::TAG_NEG]) begin
      pitch_angle <= qte_pkg::PITCH_MIN;
    end else begin
      pitch_angle <= pitch_ang;
    end
    if (rst) done <= 1'b0;
    else     done <= pitch_valid;
  end

  // roll and yaw units run in lockstep
  `QTE_ASSERT_ALWAYS(a_roll_yaw_lockstep, roll_valid == yaw_valid && roll_tag == yaw_tag)
  // pitch cannot saturate both ways at once
  `QTE_ASSERT_IMPLY(a_pitch_tag_onehot, pitch_valid, $onehot0(pitch_tag))
  // a saturated pitch sits at a quarter turn
  `QTE_ASSERT_IMPLY(a_clamp_value, done && pitch_clamped,
    pitch_angle == qte_pkg::PITCH_MAX || pitch_angle == qte_pkg::PITCH_MIN)

endmodule

// File: bench/qte_checker.sv
module qte_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic               done,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic               pitch_clamped,
  output int                 fail_count,
  output int                 angles_pending
);

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic        clamped;
  } euler_t;

  // expected results in flight, indexed by the low count bits
  localparam int PEND_DEPTH = 64;
  euler_t angle_fifo [PEND_DEPTH];
  int wr_count = 0;
  int rd_count = 0;

  localparam longint ONE_Q28 = 64'sd1 << 28;

  // floor square root, one result bit per pass
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring arctangent, result as 16 bit binary angle
  function automatic logic [15:0] vector_angle(input longint sv, input longint cv);
    longint xv, yv, zv, xs, ys, ent, half;
    longint unsigned t32;
    int k;
    half = 64'sd1 << (qte_pkg::ANGLE_BITS - 1);
    xv = cv;
    yv = sv;
    zv = 0;
    if (xv == 0 && yv == 0) return 16'd0;
    if (xv < 0) begin
      zv = (yv < 0) ? -half : half;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 32; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      k = 32 - qte_pkg::ANGLE_BITS;
      t32 = qte_pkg::ATAN_TAB[i];
      ent = (k == 0) ? longint'(t32) : longint'((t32 + (64'd1 << (k - 1))) >> k);
      if (yv < 0) begin
        xv = xv - ys;
        yv = yv + xs;
        zv = zv - ent;
      end else begin
        xv = xv + ys;
        yv = yv - xs;
        zv = zv + ent;
      end
    end
    if (qte_pkg::ANGLE_BITS > 16)
      zv = (zv + (64'sd1 << (qte_pkg::ANGLE_BITS - 17))) >>> (qte_pkg::ANGLE_BITS - 16);
    else if (qte_pkg::ANGLE_BITS < 16)
      zv = zv <<< (16 - qte_pkg::ANGLE_BITS);
    return zv[15:0];
  endfunction

  // roll, pitch and yaw of one quaternion
  function automatic euler_t quat_to_euler(input logic signed [15:0] qw, qx, qy, qz);
    longint w, x, y, z, sr, cr, sp, sy, cy;
    longint unsigned c;
    euler_t e;
    w = qw;
    x = qx;
    y = qy;
    z = qz;
    sr = 2 * (w * x + y * z);
    cr = ONE_Q28 - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q28 - 2 * (y * y + z * z);
    e.roll = vector_angle(sr, cr);
    if (sp >= ONE_Q28) begin
      e.pitch = qte_pkg::PITCH_MAX;
      e.clamped = 1'b1;
    end else if (sp <= -ONE_Q28) begin
      e.pitch = qte_pkg::PITCH_MIN;
      e.clamped = 1'b1;
    end else begin
      c = floor_sqrt((64'd1 << 56) - longint'(unsigned'(sp * sp)));
      e.pitch = vector_angle(sp, longint'(c));
      e.clamped = 1'b0;
    end
    e.yaw = vector_angle(sy, cy);
    return e;
  endfunction

  assign angles_pending = wr_count - rd_count;

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    euler_t exp_e;
    if (rst) begin
      fail_count <= 0;
      wr_count <= 0;
      rd_count <= 0;
    end else begin
      if (start && !busy) begin
        angle_fifo[wr_count[5:0]] <= quat_to_euler(quat_w, quat_x, quat_y, quat_z);
        wr_count <= wr_count + 1;
      end
      if (done) begin
        if (wr_count == rd_count) begin
          if (fail_count < 10) $display("unexpected result transfer at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = angle_fifo[rd_count[5:0]];
          rd_count <= rd_count + 1;
          if (exp_e.roll !== roll_angle || exp_e.pitch !== pitch_angle ||
              exp_e.yaw !== yaw_angle || exp_e.clamped !== pitch_clamped) begin
            if (fail_count < 10)
              $display("mismatch: exp r=%0d p=%0d y=%0d c=%0d got r=%0d p=%0d y=%0d c=%0d",
                       $signed(exp_e.roll), $signed(exp_e.pitch), $signed(exp_e.yaw),
                       exp_e.clamped, roll_angle, pitch_angle, yaw_angle, pitch_clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/tb_quaternion_to_euler_angles.sv
module tb_quaternion_to_euler_angles;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_w = '0;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic done;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic pitch_clamped;
  int fail_count;
  int angles_pending;
  int cycle_count = 0;

  always #10 clk = ~clk;

  quaternion_to_euler_angles DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
  );

  qte_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped),
    .fail_count(fail_count), .angles_pending(angles_pending)
  );

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one quaternion transfer after a random gap
  task automatic send_quat(input logic [15:0] w, x, y, z);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    do @(posedge clk); while (busy);
  endtask

  // random rotation, normalized to 1.0 = 16384
  task automatic send_unit_quat(input bit near_lock);
    real c[4];
    real norm;
    c[0] = $itor($urandom_range(0, 20000)) - 10000.0;
    c[1] = $itor($urandom_range(0, 20000)) - 10000.0;
    c[2] = $itor($urandom_range(0, 20000)) - 10000.0;
    c[3] = $itor($urandom_range(0, 20000)) - 10000.0;
    if (near_lock) begin
      // w close to +-y, z close to -x; with y close to w this drives pitch toward +pi/2
      c[2] = (($urandom_range(0, 1) == 1) ? 1.0 : -1.0) * c[0]
             + $itor($urandom_range(0, 40)) - 20.0;
      c[3] = -c[1] + $itor($urandom_range(0, 40)) - 20.0;
    end
    norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    if (norm < 1.0) norm = 1.0;
    send_quat(16'($rtoi(c[0] * 16384.0 / norm)), 16'($rtoi(c[1] * 16384.0 / norm)),
              16'($rtoi(c[2] * 16384.0 / norm)), 16'($rtoi(c[3] * 16384.0 / norm)));
  endtask

  initial begin
    int sel;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity, axis half turns, quarter turns and zero
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, -16384, 0);
    send_quat(0, 0, 0, -16384);
    send_quat(0, 0, 0, 0);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, -11585, 0, 0);
    send_quat(11585, 0, 0, 11585);
    send_quat(11585, 0, 0, -11585);
    // pitch just below and at the lock, both signs, then extremes
    send_quat(11585, 0, 11585, 0);
    send_quat(11586, 0, 11586, 0);
    send_quat(11586, 0, -11586, 0);
    send_quat(8192, -8192, 8192, 8192);
    send_quat(8192, 8192, -8192, 8192);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001);

    // mostly unit rotations, some near lock, some raw noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) send_unit_quat(1'b0);
      else if (sel < 8) send_unit_quat(1'b1);
      else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    start <= 1'b0;

    // drain, then wait with start low before the verdict
    while (angles_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
